### src/jkv_pkg.sv
// Package for the JSON key/value finder: sizes, character codes, scan phases,
// register indexes and the structs passed between the front, queue and back.
// No dependencies.
`default_nettype none
package jkv_pkg;

	// Longest key that can match and size of one value buffer.
	localparam int KEY_MAX   = 16;
	localparam int VALUE_MAX = 64;

	// Derived widths.
	localparam int KCNT_W = $clog2(KEY_MAX + 1);
	localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CNT_W  = $clog2(VALUE_MAX + 1);
	localparam int VIDX_W = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
	// The value RAM holds two buffers; the top address bit picks the buffer.
	localparam int ADDR_W    = VIDX_W + 1;
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	// Configuration register indexes.
	localparam logic [1:0] REG_KEY_LOW    = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
	localparam logic [1:0] REG_KEY_LENGTH = 2'd2;
	localparam logic [1:0] REG_OCCURRENCE = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	// Scan phases of the front.
	typedef enum logic [2:0] {
		PH_SCAN,
		PH_NAME,
		PH_COLON,
		PH_VALUE,
		PH_DONE
	} phase_t;

	// One finished record, handed from the front to the back.
	typedef struct packed {
		logic             bank;
		logic             found;
		logic             first;
		logic [CNT_W-1:0] n;
		logic             trunc;
	} rec_desc_t;

	// Write side of the value RAM.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	// Read side of the value RAM.
	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	// Status of the record queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Whitespace as JSON trimming sees it.
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c inside {[8'd9:8'd13]});
	endfunction

endpackage
`default_nettype wire

### src/jkv_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module jkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### src/jkv_queue.sv
// Two-entry record queue between the scanning front and the emitting back.
// Depends on jkv_pkg.
`default_nettype none
module jkv_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire jkv_pkg::rec_desc_t push_desc,
	input  wire logic               pop,
	output jkv_pkg::rec_desc_t      head,
	output jkv_pkg::q_stat_t        stat
);

	jkv_pkg::rec_desc_t slot_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = cnt_q[1];
	assign stat.empty = (cnt_q == 2'd0);

endmodule
`default_nettype wire

### src/jkv_front.sv
// Scanning front of the JSON key/value finder: config registers, name matching,
// value capture into the RAM and record hand-off. Depends on jkv_pkg.
`default_nettype none
module jkv_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               accept,
	input  wire logic [7:0]         text_byte,
	input  wire logic               text_last,
	output jkv_pkg::ram_wr_t        ram_wr,
	output logic                    push,
	output jkv_pkg::rec_desc_t      push_desc
);

	// Configuration registers.
	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [4:0]  key_length_q;
	logic [7:0]  occurrence_q;

	// Record state.
	jkv_pkg::phase_t            phase_q, phase_n;
	logic                       armed_q, armed_n;
	logic [jkv_pkg::KCNT_W-1:0] seen_q, seen_n;
	logic                       match_q, match_n;
	logic [7:0]                 left_q, left_n;
	logic [jkv_pkg::CNT_W-1:0]  count_q, count_n;
	logic [jkv_pkg::CNT_W-1:0]  end_q, end_n;
	logic                       ovf_q, ovf_n;
	logic [7:0]                 first_byte_q, first_byte_n;
	logic                       bank_q;

	logic                       found;
	logic [jkv_pkg::CNT_W-1:0]  rec_end;
	logic                       drop_first;
	logic [127:0]               key_all;
	logic [7:0]                 key_ch;

	// Key character at the current name position.
	assign key_all = {key_high_q, key_low_q};
	assign key_ch  = key_all[8 * seen_q[jkv_pkg::KIDX_W-1:0] +: 8];

	// Next record state for the accepted byte.
	always_comb begin
		phase_n      = phase_q;
		armed_n      = armed_q;
		seen_n       = seen_q;
		match_n      = match_q;
		left_n       = left_q;
		count_n      = count_q;
		end_n        = end_q;
		ovf_n        = ovf_q;
		first_byte_n = first_byte_q;
		ram_wr.we    = 1'b0;
		ram_wr.addr  = {bank_q, count_q[jkv_pkg::VIDX_W-1:0]};
		ram_wr.data  = text_byte;
		if (accept) begin
			case (phase_q)
				jkv_pkg::PH_SCAN: begin
					if (armed_q && text_byte == jkv_pkg::CH_QUOTE) begin
						armed_n = 1'b0;
						seen_n  = '0;
						match_n = 1'b1;
						phase_n = jkv_pkg::PH_NAME;
					end else if (text_byte inside {jkv_pkg::CH_COMMA, jkv_pkg::CH_LBRACE,
						jkv_pkg::CH_LBRACK}) begin
						armed_n = 1'b1;
					end
				end
				jkv_pkg::PH_NAME: begin
					if (text_byte == jkv_pkg::CH_QUOTE) begin
						if (match_q && 5'(seen_q) == key_length_q) begin
							left_n = left_q - 8'd1;
						end
						phase_n = (left_n == 8'd0) ? jkv_pkg::PH_COLON : jkv_pkg::PH_SCAN;
					end else if (32'(seen_q) < jkv_pkg::KEY_MAX) begin
						if (text_byte != key_ch) begin
							match_n = 1'b0;
						end
						seen_n = seen_q + 1'b1;
					end else begin
						match_n = 1'b0;
					end
				end
				jkv_pkg::PH_COLON: begin
					if (text_byte == jkv_pkg::CH_COLON) begin
						phase_n = jkv_pkg::PH_VALUE;
					end
				end
				jkv_pkg::PH_VALUE: begin
					if (text_byte inside {jkv_pkg::CH_COMMA, jkv_pkg::CH_RBRACE,
						jkv_pkg::CH_RBRACK}) begin
						phase_n = jkv_pkg::PH_DONE;
					end else if (count_q == '0 && jkv_pkg::is_space(text_byte)) begin
						// Leading whitespace is skipped.
					end else if (32'(count_q) < jkv_pkg::VALUE_MAX) begin
						ram_wr.we = 1'b1;
						count_n   = count_q + 1'b1;
						if (!jkv_pkg::is_space(text_byte)) begin
							end_n = count_q + 1'b1;
						end
						if (count_q == '0) begin
							first_byte_n = text_byte;
						end
					end else if (!jkv_pkg::is_space(text_byte)) begin
						ovf_n = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Record summary from the state after the last byte.
	assign found      = (phase_n == jkv_pkg::PH_COLON) || (phase_n == jkv_pkg::PH_VALUE) ||
		(phase_n == jkv_pkg::PH_DONE);
	assign rec_end    = found ? end_n : '0;
	assign drop_first = (32'(rec_end) >= 2) && (first_byte_n == jkv_pkg::CH_QUOTE);

	// A quoted value loses both its opening and its closing byte.
	assign push            = accept && text_last;
	assign push_desc.bank  = bank_q;
	assign push_desc.found = found;
	assign push_desc.first = drop_first;
	assign push_desc.n     = rec_end - jkv_pkg::CNT_W'({drop_first, 1'b0});
	assign push_desc.trunc = found && ovf_n;

	// Config registers and record state; the last byte of a record clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= '0;
			key_high_q   <= '0;
			key_length_q <= '0;
			occurrence_q <= 8'd1;
			phase_q      <= jkv_pkg::PH_SCAN;
			armed_q      <= 1'b0;
			seen_q       <= '0;
			match_q      <= 1'b1;
			left_q       <= 8'd1;
			count_q      <= '0;
			end_q        <= '0;
			ovf_q        <= 1'b0;
			bank_q       <= 1'b0;
		end else begin
			if (push) begin
				phase_q <= jkv_pkg::PH_SCAN;
				armed_q <= 1'b0;
				seen_q  <= '0;
				match_q <= 1'b1;
				left_q  <= occurrence_q;
				count_q <= '0;
				end_q   <= '0;
				ovf_q   <= 1'b0;
				bank_q  <= ~bank_q;
			end else begin
				phase_q <= phase_n;
				armed_q <= armed_n;
				seen_q  <= seen_n;
				match_q <= match_n;
				left_q  <= left_n;
				count_q <= count_n;
				end_q   <= end_n;
				ovf_q   <= ovf_n;
			end
			if (cfg_we) begin
				case (cfg_index)
					jkv_pkg::REG_KEY_LOW:    key_low_q    <= cfg_data;
					jkv_pkg::REG_KEY_HIGH:   key_high_q   <= cfg_data;
					jkv_pkg::REG_KEY_LENGTH: key_length_q <= cfg_data[4:0];
					jkv_pkg::REG_OCCURRENCE: begin
						occurrence_q <= cfg_data[7:0];
						left_q       <= cfg_data[7:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// First value byte, needed for the quote check.
	always_ff @(posedge clk) begin
		first_byte_q <= first_byte_n;
	end

endmodule
`default_nettype wire

### src/jkv_back.sv
// Emitting back of the JSON key/value finder: walks each queued record through
// the value RAM and drives the output register. Depends on jkv_pkg.
`default_nettype none
module jkv_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire jkv_pkg::rec_desc_t head,
	input  wire jkv_pkg::q_stat_t   stat,
	output logic                    pop,
	output jkv_pkg::ram_rd_t        ram_rd,
	input  wire logic [7:0]         ram_rdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,
	output logic                    m_tlast,
	output logic [2:0]              m_tuser
);

	logic                      valid_q;
	logic                      last_q;
	logic                      found_q;
	logic                      empty_q;
	logic                      trunc_q;
	logic [jkv_pkg::CNT_W-1:0] k_q;

	logic                      advance;
	logic                      issue;
	logic                      head_empty;
	logic                      item_last;

	// The output register moves when it is empty or being taken.
	assign advance    = !valid_q || m_tready;
	assign issue      = advance && !stat.empty;
	assign head_empty = (head.n == '0);
	assign item_last  = head_empty || (k_q + 1'b1 == head.n);
	assign pop        = issue && item_last;

	// RAM read of the next value byte; the data lands with the output register.
	assign ram_rd.re   = issue && !head_empty;
	assign ram_rd.addr = {head.bank,
		jkv_pkg::VIDX_W'(k_q + jkv_pkg::CNT_W'(head.first))};

	// Item counter and output control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else if (advance) begin
			valid_q <= issue;
			if (issue) begin
				k_q <= item_last ? '0 : k_q + 1'b1;
			end
		end
	end

	// Output side fields.
	always_ff @(posedge clk) begin
		if (issue) begin
			last_q  <= item_last;
			found_q <= head.found;
			empty_q <= head_empty;
			trunc_q <= head.trunc;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = empty_q ? 8'd0 : ram_rdata;
	assign m_tlast  = last_q;
	assign m_tuser  = {trunc_q, empty_q, found_q};

endmodule
`default_nettype wire

### src/json_key_value_finder_top.sv
// Top level of the JSON key/value finder: front, record queue, back and value RAM.
// Depends on jkv_pkg, jkv_ram, jkv_queue, jkv_front and jkv_back.
//
// The block scans a JSON record one byte per cycle and, on the record's last byte,
// hands the value of the requested occurrence of the configured key to the output
// side, which emits it one word per cycle while the receiver is ready (or a single
// empty word). The value RAM holds two buffers, so the next record is scanned while
// the previous one drains; input is taken at one byte per cycle while fewer than two
// finished records wait, and stalls only when both buffers are still being emitted.
// No clearing pass runs after reset. Configuration is written by the user while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module json_key_value_finder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	input  wire logic        s_tlast,   // text_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] value_byte
	output logic             m_tlast,   // value_last
	output logic [2:0]       m_tuser    // [0] key_found, [1] value_empty, [2] value_truncated
);

	jkv_pkg::ram_wr_t   ram_wr;
	jkv_pkg::ram_rd_t   ram_rd;
	logic [7:0]         ram_rdata;
	jkv_pkg::rec_desc_t push_desc;
	jkv_pkg::rec_desc_t head;
	jkv_pkg::q_stat_t   stat;
	logic               push;
	logic               pop;
	logic               accept;

	// A word is taken while a buffer is free.
	assign s_tready = !stat.full;
	assign accept   = s_tvalid && s_tready;

	jkv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.text_byte (s_tdata),
		.text_last (s_tlast),
		.ram_wr    (ram_wr),
		.push      (push),
		.push_desc (push_desc)
	);

	jkv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	jkv_ram #(
		.WIDTH (8),
		.DEPTH (jkv_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.re),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

	jkv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.ram_rd    (ram_rd),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

`ifndef ASSERT_OFF
	// The front never writes the buffer that the back is reading.
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr.we && ram_rd.re) |-> (ram_wr.addr[jkv_pkg::ADDR_W-1] !=
		ram_rd.addr[jkv_pkg::ADDR_W-1]))
		else $error("value RAM write and read hit the same buffer");

	// An empty result is always the only and last word of its record.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tlast)
		else $error("empty result not marked last");

	// A value byte is only emitted when the key was found.
	a_byte_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> m_tuser[0])
		else $error("value byte emitted without a found key");
`endif

endmodule
`default_nettype wire

### verif/json_key_value_finder_checker.sv
`timescale 1ns / 1ps
// Checker for the JSON key/value finder: watches the register port and both streams,
// predicts the value words of each record and compares them with what leaves the block.
// Depends on jkv_pkg for sizes, character codes, phases and register indexes.
module json_key_value_finder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic [2:0]  m_tuser,
	output int          mismatches,
	output int          backlog
);
	import jkv_pkg::*;

	localparam int PRINT_MAX = 40;

	// One output word as the block should send it.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       found;
		logic       empty;
		logic       trunc;
	} value_word_t;

	value_word_t value_words[$];

	// Shadow of the configuration registers.
	logic [63:0] key_lo;
	logic [63:0] key_hi;
	logic [4:0]  key_len;
	logic [7:0]  occ_reg;

	// Shadow of the record scan state.
	phase_t            phase;
	logic              armed;
	logic [KCNT_W-1:0] name_len;
	logic              name_ok;
	logic [7:0]        occ_left;
	logic [7:0]        stash [VALUE_MAX];
	logic [CNT_W-1:0]  stash_cnt;
	logic [CNT_W-1:0]  stash_end;
	logic              overflow;

	int fail_count = 0;
	int words_seen = 0;

	function automatic logic blank(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] key_char(input logic [3:0] idx);
		return idx[3] ? key_hi[idx[2:0] * 8 +: 8] : key_lo[idx[2:0] * 8 +: 8];
	endfunction

	task automatic report(input string what);
		fail_count++;
		if (fail_count <= PRINT_MAX) begin
			$display("%0t ns: %s", $time, what);
		end
	endtask

	task automatic reset_record();
		phase = PH_SCAN;
		armed = 1'b0;
		name_len = '0;
		name_ok = 1'b1;
		occ_left = occ_reg;
		stash_cnt = '0;
		stash_end = '0;
		overflow = 1'b0;
	endtask

	task automatic expect_word(input logic [7:0] ch, input logic last, input logic found,
			input logic empty, input logic trunc);
		value_word_t w;
		w.ch = ch;
		w.last = last;
		w.found = found;
		w.empty = empty;
		w.trunc = trunc;
		value_words.push_back(w);
	endtask

	// Advance the scan by one text character.
	task automatic scan_char(input logic [7:0] c);
		case (phase)
			PH_SCAN: begin
				if (armed && c == CH_QUOTE) begin
					armed = 1'b0;
					name_len = '0;
					name_ok = 1'b1;
					phase = PH_NAME;
				end else if (c == CH_COMMA || c == CH_LBRACE || c == CH_LBRACK) begin
					armed = 1'b1;
				end
			end
			PH_NAME: begin
				if (c == CH_QUOTE) begin
					// The counter wraps, so occurrence zero selects the first non-matching name.
					if (name_ok && name_len == key_len) begin
						occ_left = occ_left - 8'd1;
					end
					phase = (occ_left == 8'd0) ? PH_COLON : PH_SCAN;
				end else if (name_len < KEY_MAX) begin
					if (c != key_char(name_len[3:0])) begin
						name_ok = 1'b0;
					end
					name_len = name_len + 1'b1;
				end else begin
					name_ok = 1'b0;
				end
			end
			PH_COLON: begin
				if (c == CH_COLON) begin
					phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK) begin
					phase = PH_DONE;
				end else if (stash_cnt == 0 && blank(c)) begin
					// Leading whitespace is not stored.
				end else if (stash_cnt < VALUE_MAX) begin
					stash[stash_cnt] = c;
					stash_cnt = stash_cnt + 1'b1;
					if (!blank(c)) begin
						stash_end = stash_cnt;
					end
				end else if (!blank(c)) begin
					overflow = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	// At the end of a record, queue the value words it should produce.
	task automatic emit_value();
		logic             found;
		logic [CNT_W-1:0] first;
		logic [CNT_W-1:0] stop;
		logic [CNT_W-1:0] n;
		int               k;
		found = (phase != PH_SCAN) && (phase != PH_NAME);
		first = '0;
		stop = found ? stash_end : '0;
		// A quoted value loses its first and last stored byte, even when cut short.
		if (stop >= 2 && stash[0] == CH_QUOTE) begin
			first = 1;
			stop = stop - 1'b1;
		end
		n = stop - first;
		if (n == 0) begin
			expect_word(8'd0, 1'b1, found, 1'b1, found ? overflow : 1'b0);
		end else begin
			for (k = 0; k < n; k++) begin
				expect_word(stash[first + k], k + 1 == n, 1'b1, 1'b0, overflow);
			end
		end
		reset_record();
	endtask

	// Compare one accepted output word with the oldest expectation.
	task automatic check_word();
		value_word_t want;
		words_seen++;
		if (value_words.size() == 0) begin
			report($sformatf("word %0d arrived with nothing expected: byte %02h tuser %b",
				words_seen, m_tdata, m_tuser));
		end else begin
			want = value_words.pop_front();
			if (m_tdata !== want.ch) begin
				report($sformatf("word %0d value_byte %02h, expected %02h",
					words_seen, m_tdata, want.ch));
			end
			if (m_tlast !== want.last) begin
				report($sformatf("word %0d value_last %b, expected %b",
					words_seen, m_tlast, want.last));
			end
			if (m_tuser[0] !== want.found) begin
				report($sformatf("word %0d key_found %b, expected %b",
					words_seen, m_tuser[0], want.found));
			end
			if (m_tuser[1] !== want.empty) begin
				report($sformatf("word %0d value_empty %b, expected %b",
					words_seen, m_tuser[1], want.empty));
			end
			if (m_tuser[2] !== want.trunc) begin
				report($sformatf("word %0d value_truncated %b, expected %b",
					words_seen, m_tuser[2], want.trunc));
			end
		end
	endtask

	// Registers, input words and output words, all sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			key_len = '0;
			occ_reg = 8'd1;
			reset_record();
			value_words.delete();
		end else begin
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					REG_KEY_LOW:    key_lo = cfg_data;
					REG_KEY_HIGH:   key_hi = cfg_data;
					REG_KEY_LENGTH: key_len = cfg_data[4:0];
					REG_OCCURRENCE: begin
						occ_reg = cfg_data[7:0];
						occ_left = cfg_data[7:0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
				scan_char(s_tdata);
				if (s_tlast) begin
					emit_value();
				end
			end
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				check_word();
			end
		end
		backlog <= value_words.size();
		mismatches <= fail_count;
	end

endmodule

### verif/json_key_value_finder_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the JSON key/value finder: clock, reset, key settings and
// JSON-like records with random pacing. Depends on jkv_pkg, the block and the checker.
module json_key_value_finder_top_test;
	import jkv_pkg::*;

	localparam int LIMIT_NS     = 4_000_000;
	localparam int SETTLE       = 16;
	localparam int PHASES       = 9;
	localparam int RANDOM_CHARS = 360;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_KEY_LOW;
	logic [63:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;
	int          mismatches;
	int          backlog;

	// Key as last written, used to build names that match.
	logic [7:0] key_text [KEY_MAX];
	int         key_len_now = 0;

	logic [7:0] rec[$];
	int         chars_sent = 0;
	int         burst_left = 0;
	logic [31:0] rx_cycle = '0;
	logic [1:0]  rx_mode = 2'd0;

	json_key_value_finder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	json_key_value_finder_checker value_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.backlog(backlog)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: the stall pattern is redrawn at random, from always ready to mostly stalled.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 48 == 0) begin
			rx_mode <= 2'($urandom_range(0, 3));
		end
		case (rx_mode)
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= (rx_cycle[1:0] == 2'b11);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
		return c;
	endfunction

	function automatic logic [7:0] value_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK);
		return c;
	endfunction

	function automatic logic [7:0] blank_char();
		return ($urandom_range(0, 2) == 0) ? 8'd32 : 8'($urandom_range(9, 13));
	endfunction

	// Random key characters, kept free of quotes so that matching names can be built.
	function automatic logic [63:0] rand_key_word();
		logic [63:0] w;
		int          i;
		for (i = 0; i < 8; i++) begin
			w[i * 8 +: 8] = name_char();
		end
		return w;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic load_key(input logic [63:0] lo, input logic [63:0] hi, input int len,
			input int occ);
		int i;
		write_reg(REG_KEY_LOW, lo);
		write_reg(REG_KEY_HIGH, hi);
		write_reg(REG_KEY_LENGTH, 64'(len));
		write_reg(REG_OCCURRENCE, 64'(occ));
		cfg_we <= 1'b0;
		for (i = 0; i < 8; i++) begin
			key_text[i] = lo[i * 8 +: 8];
			key_text[i + 8] = hi[i * 8 +: 8];
		end
		key_len_now = len;
	endtask

	// Send one text word; bursts of random length are separated by random gaps.
	task automatic send_char(input logic [7:0] ch, input logic last);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		chars_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_record();
		int i;
		for (i = 0; i < rec.size(); i++) begin
			send_char(rec[i], i == rec.size() - 1);
		end
	endtask

	task automatic send_text(input string s);
		int i;
		rec.delete();
		for (i = 0; i < s.len(); i++) begin
			rec.push_back(s[i]);
		end
		send_record();
	endtask

	// Stop sending, wait for every expected word, then let the block go quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_blank();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
		repeat (n) rec.push_back(blank_char());
	endtask

	// A quoted name: the key, a near miss, an over-long name or a random one.
	task automatic add_name();
		logic [7:0] nm[$];
		int         pick;
		int         i;
		int         pos;
		pick = $urandom_range(0, 11);
		if (pick < 8) begin
			for (i = 0; i < key_len_now; i++) begin
				nm.push_back(i < KEY_MAX ? key_text[i] : name_char());
			end
			if (pick >= 6) begin
				case ($urandom_range(0, 2))
					0: begin
						if (nm.size() > 0) begin
							pos = $urandom_range(0, nm.size() - 1);
							nm[pos] = (nm[pos] == 8'h23) ? 8'h21 : nm[pos] ^ 8'h01;
						end
					end
					1: begin
						if (nm.size() > 0) begin
							void'(nm.pop_back());
						end
					end
					default: nm.push_back(name_char());
				endcase
			end
		end else if (pick == 8) begin
			repeat ($urandom_range(17, 20)) nm.push_back(name_char());
		end else begin
			repeat ($urandom_range(0, 5)) nm.push_back(name_char());
		end
		rec.push_back(CH_QUOTE);
		foreach (nm[i]) begin
			rec.push_back(nm[i]);
		end
		rec.push_back(CH_QUOTE);
	endtask

	task automatic add_value();
		int kind;
		kind = $urandom_range(0, 9);
		add_blank();
		case (kind)
			0, 1, 2: repeat ($urandom_range(1, 4)) rec.push_back(8'h30 + 8'($urandom_range(0, 9)));
			3, 4: begin
				rec.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 6)) rec.push_back(8'($urandom_range(8'h41, 8'h7A)));
				rec.push_back(CH_QUOTE);
			end
			5: begin
				rec.push_back(CH_LBRACK);
				rec.push_back(8'h31);
				rec.push_back(CH_COMMA);
				rec.push_back(8'h32);
				rec.push_back(CH_RBRACK);
			end
			6: repeat ($urandom_range(1, 5)) rec.push_back(value_char());
			7: begin
				// Near or past the size of the value buffer, often quoted, sometimes padded with blanks.
				if ($urandom_range(0, 1) == 0) begin
					rec.push_back(CH_QUOTE);
				end
				repeat ($urandom_range(60, 80)) begin
					rec.push_back($urandom_range(0, 5) == 0 ? blank_char() : value_char());
				end
				repeat ($urandom_range(0, 6)) rec.push_back(blank_char());
			end
			8: begin
				// Nothing between the colon and the terminator.
			end
			default: rec.push_back(CH_QUOTE);
		endcase
		add_blank();
	endtask

	// Mostly well-formed records with random content, some noise and some cut short.
	task automatic make_record();
		logic [7:0] specials [7];
		int         form;
		int         m;
		int         keep;
		specials = '{CH_QUOTE, CH_COLON, CH_COMMA, CH_LBRACE, CH_LBRACK, CH_RBRACE, CH_RBRACK};
		rec.delete();
		form = $urandom_range(0, 7);
		if (form == 0) begin
			repeat ($urandom_range(1, 12)) begin
				rec.push_back($urandom_range(0, 2) == 0 ? specials[$urandom_range(0, 6)]
					: 8'($urandom_range(0, 255)));
			end
		end else begin
			rec.push_back($urandom_range(0, 3) == 0 ? CH_LBRACK : CH_LBRACE);
			for (m = 0; m < $urandom_range(1, 4); m++) begin
				if (m > 0) begin
					rec.push_back(CH_COMMA);
				end
				add_blank();
				add_name();
				add_blank();
				if ($urandom_range(0, 9) != 0) begin
					rec.push_back(CH_COLON);
				end
				add_value();
			end
			rec.push_back(CH_RBRACE);
			if (form == 1) begin
				keep = $urandom_range(1, rec.size());
				while (rec.size() > keep) begin
					void'(rec.pop_back());
				end
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int p;
		int budget;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short directed records with the one-character key "a".
		load_key(64'h61, 64'h0, 1, 1);
		send_text("{\"a\":1}");
		send_text("{\"a\":\"}");
		send_text("{\"a\"}");
		send_text("x");
		settle();

		// Random records under a sequence of key settings, extremes included.
		// Each setting gets at least one record; the total stays near the character budget.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: load_key('0, '0, 0, 1);
				1: load_key(rand_key_word(), rand_key_word(), $urandom_range(1, 8), 1);
				2: load_key('1, '1, KEY_MAX, 2);
				3: load_key(rand_key_word(), rand_key_word(), $urandom_range(1, 4), 0);
				4: load_key(rand_key_word(), rand_key_word(), KEY_MAX + 1, 1);
				5: load_key(rand_key_word(), rand_key_word(), 31, 1);
				6: load_key(rand_key_word(), rand_key_word(), KEY_MAX, 255);
				7: load_key(rand_key_word(), rand_key_word(), $urandom_range(1, KEY_MAX),
					$urandom_range(1, 3));
				default: load_key(rand_key_word(), rand_key_word(), $urandom_range(1, 3), 1);
			endcase
			budget = (p + 1) * RANDOM_CHARS / PHASES;
			do begin
				make_record();
				send_record();
			end while (chars_sent < budget);
			settle();
		end

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
src/jkv_pkg.sv
src/jkv_ram.sv
src/jkv_queue.sv
src/jkv_front.sv
src/jkv_back.sv
src/json_key_value_finder_top.sv
verif/json_key_value_finder_checker.sv
verif/json_key_value_finder_top_test.sv
